>>> rtl/hff_pkg.sv
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types, constants, control store and character helpers for the
// hexadecimal field formatter.
// ----------------------------------------------------------------------------
package hff_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int VALUE_BITS_DEF = 64;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int CNT_W      = 7;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CH_SPACE_C = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS_C  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO_C  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPX_C   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWX_C  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPA_C   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWA_C  = 8'h61;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_NORM   = 4'd1,
        ST_CALC   = 4'd2,
        ST_LEAD   = 4'd3,
        ST_SIGN   = 4'd4,
        ST_PRE0   = 4'd5,
        ST_PREX   = 4'd6,
        ST_ZEROS  = 4'd7,
        ST_DIGITS = 4'd8,
        ST_TRAIL  = 4'd9
    } step_t;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_NORM,
        OP_CALC,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LEAD,
        C_SIGN,
        C_PREFIX,
        C_ZPAD,
        C_LJUST
    } cond_t;

    typedef enum logic [1:0] {
        CNT_ONCE,
        CNT_PAD,
        CNT_DIG
    } cnt_t;

    typedef enum logic [2:0] {
        CH_SPACE,
        CH_SIGN,
        CH_ZERO,
        CH_X,
        CH_DIGIT
    } chr_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        cnt_t  cnt;
        chr_t  chr;
        step_t nxt;
    } ucode_t;

    typedef struct packed {
        logic   load;
        logic   norm;
        logic   calc;
        logic   emit;
        ucode_t cw;
    } cmd_t;

    typedef struct packed {
        logic norm_more;
        logic active;
        logic final_rep;
        logic out_free;
    } status_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            ST_IDLE:   w = '{OP_WAIT, C_ALWAYS, CNT_ONCE, CH_SPACE, ST_NORM};
            ST_NORM:   w = '{OP_NORM, C_ALWAYS, CNT_ONCE, CH_SPACE, ST_CALC};
            ST_CALC:   w = '{OP_CALC, C_ALWAYS, CNT_ONCE, CH_SPACE, ST_LEAD};
            ST_LEAD:   w = '{OP_EMIT, C_LEAD,   CNT_PAD,  CH_SPACE, ST_SIGN};
            ST_SIGN:   w = '{OP_EMIT, C_SIGN,   CNT_ONCE, CH_SIGN,  ST_PRE0};
            ST_PRE0:   w = '{OP_EMIT, C_PREFIX, CNT_ONCE, CH_ZERO,  ST_PREX};
            ST_PREX:   w = '{OP_EMIT, C_PREFIX, CNT_ONCE, CH_X,     ST_ZEROS};
            ST_ZEROS:  w = '{OP_EMIT, C_ZPAD,   CNT_PAD,  CH_ZERO,  ST_DIGITS};
            ST_DIGITS: w = '{OP_EMIT, C_ALWAYS, CNT_DIG,  CH_DIGIT, ST_TRAIL};
            ST_TRAIL:  w = '{OP_EMIT, C_LJUST,  CNT_PAD,  CH_SPACE, ST_IDLE};
            default:   w = '{OP_WAIT, C_ALWAYS, CNT_ONCE, CH_SPACE, ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO_C + {4'd0, nib};
        end else begin
            c = (upper ? CH_UPA_C : CH_LOWA_C) + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> rtl/hff_sequencer.sv
// ----------------------------------------------------------------------------
// hff_sequencer
// Step counter over the control store; picks the next step from the
// control word and the datapath status.
// ----------------------------------------------------------------------------
module hff_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hff_pkg::status_t  status,
    output hff_pkg::cmd_t     cmd
);

    hff_pkg::step_t  step_reg;
    hff_pkg::step_t  step_next;
    hff_pkg::ucode_t cw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= hff_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        cw        = hff_pkg::ucode_rom(step_reg);
        step_next = step_reg;
        cmd       = '0;
        cmd.cw    = cw;
        s_tready  = 1'b0;
        case (cw.op)
            hff_pkg::OP_WAIT: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load  = 1'b1;
                    step_next = cw.nxt;
                end
            end
            hff_pkg::OP_NORM: begin
                if (status.norm_more) begin
                    cmd.norm = 1'b1;
                end else begin
                    step_next = cw.nxt;
                end
            end
            hff_pkg::OP_CALC: begin
                cmd.calc  = 1'b1;
                step_next = cw.nxt;
            end
            hff_pkg::OP_EMIT: begin
                if (!status.active) begin
                    step_next = cw.nxt;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.final_rep) begin
                        step_next = cw.nxt;
                    end
                end
            end
            default: begin
                step_next = hff_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/hff_datapath.sv
// ----------------------------------------------------------------------------
// hff_datapath
// Operand registers, digit count, pad and total counters, character
// selection and the output register.
// ----------------------------------------------------------------------------
module hff_datapath #(
    parameter int MAX_WIDTH  = hff_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = hff_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hff_pkg::cmd_t                   cmd,
    output hff_pkg::status_t                status,
    input  logic [hff_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hff_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    localparam int NIB   = (VALUE_BITS + 3) / 4;
    localparam int VW    = NIB * 4;
    localparam int DW    = $clog2(NIB + 1);
    localparam int CW    = hff_pkg::CNT_W;

    logic [VW-1:0] val_reg;
    logic [DW-1:0] dig_reg;
    logic          upper_reg, ljust_reg, zpad_reg, fsign_reg, ssign_reg, prefix_reg;
    logic [CW-1:0] width_reg;
    logic [CW-1:0] pad_reg;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] emitted_reg;

    logic                          m_tvalid_reg;
    logic [hff_pkg::CHAR_W-1:0]    char_reg;
    logic                          last_reg;
    logic [CW-1:0]                 count_reg;

    logic [CW-1:0]              in_width;
    logic [CW-1:0]              content;
    logic                       cond_ok;
    logic [CW-1:0]              remaining;
    logic [hff_pkg::CHAR_W-1:0] char_sel;
    logic                       out_free;
    logic                       is_last;
    logic [3:0]                 top_nib;

    assign top_nib  = val_reg[VW-1 -: 4];
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_width = (s_tdata[76:70] > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : s_tdata[76:70];
    assign content  = CW'(dig_reg) + {{(CW-2){1'b0}}, prefix_reg, 1'b0}
                      + {{(CW-1){1'b0}}, (fsign_reg | ssign_reg)};
    assign is_last  = ((emitted_reg + 1'b1) == total_reg);

    always_comb begin
        case (cmd.cw.cond)
            hff_pkg::C_ALWAYS: cond_ok = 1'b1;
            hff_pkg::C_LEAD:   cond_ok = !zpad_reg && !ljust_reg;
            hff_pkg::C_SIGN:   cond_ok = fsign_reg || ssign_reg;
            hff_pkg::C_PREFIX: cond_ok = prefix_reg;
            hff_pkg::C_ZPAD:   cond_ok = zpad_reg && !ljust_reg;
            hff_pkg::C_LJUST:  cond_ok = ljust_reg;
            default:           cond_ok = 1'b0;
        endcase
        case (cmd.cw.cnt)
            hff_pkg::CNT_ONCE: remaining = CW'(1);
            hff_pkg::CNT_PAD:  remaining = pad_reg;
            hff_pkg::CNT_DIG:  remaining = CW'(dig_reg);
            default:           remaining = '0;
        endcase
        case (cmd.cw.chr)
            hff_pkg::CH_SPACE: char_sel = hff_pkg::CH_SPACE_C;
            hff_pkg::CH_SIGN:  char_sel = fsign_reg ? hff_pkg::CH_PLUS_C : hff_pkg::CH_SPACE_C;
            hff_pkg::CH_ZERO:  char_sel = hff_pkg::CH_ZERO_C;
            hff_pkg::CH_X:     char_sel = upper_reg ? hff_pkg::CH_UPX_C : hff_pkg::CH_LOWX_C;
            hff_pkg::CH_DIGIT: char_sel = hff_pkg::hex_char(top_nib, upper_reg);
            default:           char_sel = hff_pkg::CH_SPACE_C;
        endcase
    end

    always_comb begin
        status           = '0;
        status.norm_more = (top_nib == 4'd0) && (dig_reg > DW'(1));
        status.active    = cond_ok && (remaining != '0);
        status.final_rep = (remaining == CW'(1));
        status.out_free  = out_free;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg     <= VW'(s_tdata[VALUE_BITS-1:0]);
            dig_reg     <= DW'(NIB);
            upper_reg   <= s_tdata[64];
            ljust_reg   <= s_tdata[65];
            zpad_reg    <= s_tdata[66];
            fsign_reg   <= s_tdata[67];
            ssign_reg   <= s_tdata[68];
            prefix_reg  <= s_tdata[69];
            width_reg   <= in_width;
            emitted_reg <= '0;
        end
        if (cmd.norm) begin
            val_reg <= {val_reg[VW-5:0], 4'd0};
            dig_reg <= dig_reg - 1'b1;
        end
        if (cmd.calc) begin
            pad_reg   <= (width_reg > content) ? (width_reg - content) : '0;
            total_reg <= (width_reg > content) ? width_reg : content;
        end
        if (cmd.emit) begin
            emitted_reg <= emitted_reg + 1'b1;
            char_reg    <= char_sel;
            last_reg    <= is_last;
            count_reg   <= is_last ? total_reg : '0;
            if (cmd.cw.cnt == hff_pkg::CNT_PAD) begin
                pad_reg <= pad_reg - 1'b1;
            end
            if (cmd.cw.cnt == hff_pkg::CNT_DIG) begin
                val_reg <= {val_reg[VW-5:0], 4'd0};
                dig_reg <= dig_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, count_reg, char_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/hex_field_formatter.sv
// ----------------------------------------------------------------------------
// hex_field_formatter
// Formats one unsigned number as a hexadecimal text field with sign, prefix,
// padding and minimum width, one ASCII character per output transaction.
//
// Input channel s_: one transaction per number; s_tdata carries the value and
// the formatting flags. s_tready is high only while the sequencer waits for a
// new number, so one number is handled at a time.
// Output channel m_: one transaction per character, tlast on the final one,
// which also carries the field's character count in m_tdata.
// Sequence: a load step, a normalise step that drops leading zero digits, a
// step that sizes the padding, then one emit step per part of the field (lead
// spaces, sign, prefix 0 and x, zeros, digits, trailing spaces); a part that
// is not used is passed over. Output is bounded by the control program and
// the single character output register.
// Reset clears the step counter and the output valid flag; the block then waits
// for a number. When the receiver stalls, the current character holds in the
// output register and the next character step waits until it is taken.
// ----------------------------------------------------------------------------
module hex_field_formatter #(
    parameter int MAX_WIDTH  = hff_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = hff_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value[63:0], upper_case[64], left_justify[65], zero_pad[66],
    // force_sign[67], space_sign[68], hex_prefix[69], field_width[76:70]
    input  logic [hff_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // character[7:0], total_count[14:8]
    output logic [hff_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    hff_pkg::cmd_t    cmd;
    hff_pkg::status_t status;

    hff_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hff_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
